// ===== rtl/core/vtfq_pkg.sv =====
// ----------------------------------------------------------------------------
// vtfq_pkg: shared definitions for the virtual time fair queue
// Field widths, operation codes, the shared adder's operation and the
// response record used by the scheduler and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package vtfq_pkg;

  // Fixed field widths of the request and response channels.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned FLOW_W   = 4;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned HANDLE_W = 16;

  // Request operations.
  localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHED  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } vtfq_alu_op_e;

  // Stored packet descriptor.
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
  } vtfq_pkt_t;

  // One response record.
  typedef struct packed {
    logic                grant_valid;
    logic [FLOW_W-1:0]   grant_flow;
    logic [LEN_W-1:0]    grant_len;
    logic [HANDLE_W-1:0] grant_handle;
    logic                done_valid;
    logic [FLOW_W-1:0]   done_flow;
    logic                error;
  } vtfq_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/vtfq_if.sv =====
// ----------------------------------------------------------------------------
// vtfq_if: request and response channels of the fair queue
// Valid/ready channels; a request moves on an edge where both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtfq_req_if import vtfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [FLOW_W-1:0]   flow_id;
  logic [LEN_W-1:0]    packet_len;
  logic [HANDLE_W-1:0] packet_handle;

  modport source (output valid, output operation, output flow_id,
                  output packet_len, output packet_handle, input ready);
  modport sink   (input valid, input operation, input flow_id,
                  input packet_len, input packet_handle, output ready);
endinterface

interface vtfq_rsp_if import vtfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                grant_valid;
  logic [FLOW_W-1:0]   grant_flow;
  logic [LEN_W-1:0]    grant_len;
  logic [HANDLE_W-1:0] grant_handle;
  logic                done_valid;
  logic [FLOW_W-1:0]   done_flow;
  logic                error;

  modport source (output valid, output grant_valid, output grant_flow,
                  output grant_len, output grant_handle, output done_valid,
                  output done_flow, output error, input ready);
  modport sink   (input valid, input grant_valid, input grant_flow,
                  input grant_len, input grant_handle, input done_valid,
                  input done_flow, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vtfq_alu.sv =====
// ----------------------------------------------------------------------------
// vtfq_alu: shared adder of the fair queue
// One adder with carry out, used for time advance, wrap correction and the
// less-than compare of the minimum search.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfq_alu import vtfq_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  vtfq_alu_op_e op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output logic         carry_o
);

  logic [W:0]   sum;
  logic [W-1:0] b_opnd;

  // Subtraction is a plus the complement of b plus one; a carry then means a >= b.
  assign b_opnd = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign sum    = {1'b0, a_i} + {1'b0, b_opnd} + {{W{1'b0}}, (op_i == ALU_SUB)};
  assign res_o   = sum[W-1:0];
  assign carry_o = sum[W];

endmodule

`default_nettype wire

// ===== rtl/core/virtual_time_fair_queue.sv =====
// ----------------------------------------------------------------------------
// virtual_time_fair_queue: virtual time fair queueing packet scheduler
// Keeps a virtual time and one queued descriptor per flow and grants the
// queued flow with the lowest time, ties to the lowest flow index.
//
//   Channel | Direction | Handshake        | Contents
//   req_i   | in        | valid/ready      | operation, flow_id, packet_len, packet_handle
//   rsp_o   | out       | valid/ready      | grant, done and error flags with their fields
//
// Rejected requests and flow resets answer straight from the idle state; a
// finish without a wrap answers from S_FIN_ADD. A minimum search reads the
// time memory one entry a cycle through the single read port, and a wrap
// adds a correction sweep that rewrites every queued time. Reset is
// asynchronous and needs no clearing pass.
// The response register holds a result until it is taken; a new request is
// taken in the same cycle as the old response leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_time_fair_queue import vtfq_pkg::*; #(
  parameter int unsigned NUM_FLOWS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vtfq_req_if.sink    req_i,
  vtfq_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(NUM_FLOWS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_FLOWS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_CUR_LD     = 4'd1;
  localparam logic [3:0] S_SCAN       = 4'd2;
  localparam logic [3:0] S_SCAN_END   = 4'd3;
  localparam logic [3:0] S_SUBMIT_FIN = 4'd4;
  localparam logic [3:0] S_GRANT_LD   = 4'd5;
  localparam logic [3:0] S_FIN_ADD    = 4'd6;
  localparam logic [3:0] S_SWEEP      = 4'd7;
  localparam logic [3:0] S_WRAP_SUB   = 4'd8;
  localparam logic [3:0] S_WRAP_ADD   = 4'd9;

  // Purpose of a minimum search.
  localparam logic [1:0] K_CUR   = 2'd0;
  localparam logic [1:0] K_GRANT = 2'd1;
  localparam logic [1:0] K_WRAP  = 2'd2;

  logic [3:0]           state_q, state_d;
  logic [1:0]           kind_q, kind_d;
  logic [IDX_W-1:0]     flow_q, flow_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [HANDLE_W-1:0]  handle_q, handle_d;
  logic                 need_time_q, need_time_d;
  logic [TIME_BITS-1:0] cur_time_q, cur_time_d;
  logic [TIME_BITS-1:0] t_q, t_d;
  logic [TIME_BITS-1:0] min_q, min_d;
  logic [IDX_W-1:0]     min_idx_q, min_idx_d;
  logic                 found_q, found_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;

  logic                 sending_active_q, sending_active_d;
  logic [IDX_W-1:0]     sending_id_q, sending_id_d;
  logic [LEN_W-1:0]     sending_len_q, sending_len_d;
  logic                 prev_active_q, prev_active_d;
  logic [IDX_W-1:0]     prev_id_q, prev_id_d;
  logic                 pending_q, pending_d;
  logic [NUM_FLOWS-1:0] has_time_q, has_time_d;
  logic [NUM_FLOWS-1:0] is_queued_q, is_queued_d;

  vtfq_rsp_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;

  // Time memory and descriptor memory.
  logic [TIME_BITS-1:0] vt_mem [NUM_FLOWS];
  logic                 vt_we;
  logic [IDX_W-1:0]     vt_waddr;
  logic [TIME_BITS-1:0] vt_wdata;
  logic [IDX_W-1:0]     vt_raddr;
  logic [TIME_BITS-1:0] vt_rd_q;
  vtfq_pkt_t            lh_mem [NUM_FLOWS];
  logic                 lh_we;
  vtfq_pkt_t            lh_rd_q;

  // Shared adder.
  vtfq_alu_op_e         alu_op;
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
  logic                 alu_carry;

  logic                 accept;
  logic                 f_ok;
  logic [IDX_W-1:0]     fidx;
  logic [IDX_W-1:0]     cnt_idx;
  logic [TIME_BITS-1:0] amount;

  vtfq_alu #(.W(TIME_BITS)) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // Channel handshakes and request decode helpers.
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign f_ok        = 32'(req_i.flow_id) < NUM_FLOWS;
  assign fidx        = IDX_W'(req_i.flow_id);
  assign cnt_idx     = cnt_q[IDX_W-1:0];
  assign amount      = TIME_BITS'(sending_len_q);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.grant_valid  = res_q.grant_valid;
  assign rsp_o.grant_flow   = res_q.grant_flow;
  assign rsp_o.grant_len    = res_q.grant_len;
  assign rsp_o.grant_handle = res_q.grant_handle;
  assign rsp_o.done_valid   = res_q.done_valid;
  assign rsp_o.done_flow    = res_q.done_flow;
  assign rsp_o.error        = res_q.error;

  // Sequencer and datapath control.
  always_comb begin
    state_d          = state_q;
    kind_d           = kind_q;
    flow_d           = flow_q;
    len_d            = len_q;
    handle_d         = handle_q;
    need_time_d      = need_time_q;
    cur_time_d       = cur_time_q;
    t_d              = t_q;
    min_d            = min_q;
    min_idx_d        = min_idx_q;
    found_d          = found_q;
    cnt_d            = cnt_q;
    chk_vld_d        = chk_vld_q;
    chk_idx_d        = chk_idx_q;
    sending_active_d = sending_active_q;
    sending_id_d     = sending_id_q;
    sending_len_d    = sending_len_q;
    prev_active_d    = prev_active_q;
    prev_id_d        = prev_id_q;
    pending_d        = pending_q;
    has_time_d       = has_time_q;
    is_queued_d      = is_queued_q;
    res_d            = res_q;
    out_valid_d      = out_valid_q;
    vt_we            = 1'b0;
    vt_waddr         = flow_q;
    vt_wdata         = cur_time_q;
    vt_raddr         = sending_id_q;
    lh_we            = 1'b0;
    alu_op           = ALU_SUB;
    alu_a            = vt_rd_q;
    alu_b            = min_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (req_i.operation)
            OP_SUBMIT: begin
              if (!f_ok || is_queued_q[fidx] || (sending_active_q && sending_id_q == fidx)) begin
                res_d.error = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                flow_d      = fidx;
                len_d       = req_i.packet_len;
                handle_d    = req_i.packet_handle;
                need_time_d = !has_time_q[fidx];
                has_time_d[fidx] = 1'b1;
                if (prev_active_q && prev_id_q == fidx) begin
                  prev_active_d = 1'b0;
                end
                if (has_time_q[fidx]) begin
                  state_d = S_SUBMIT_FIN;
                end else if (sending_active_q) begin
                  // The time of the sending flow is being read this cycle.
                  state_d = S_CUR_LD;
                end else begin
                  state_d   = S_SCAN;
                  kind_d    = K_CUR;
                  cnt_d     = '0;
                  chk_vld_d = 1'b0;
                  found_d   = 1'b0;
                end
              end
            end
            OP_FINISH: begin
              if (!sending_active_q) begin
                res_d.error = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                sending_active_d = 1'b0;
                prev_active_d    = 1'b1;
                prev_id_d        = sending_id_q;
                flow_d           = sending_id_q;
                pending_d        = 1'b1;
                res_d.done_valid = 1'b1;
                res_d.done_flow  = FLOW_W'(sending_id_q);
                state_d          = S_FIN_ADD;
              end
            end
            OP_SCHED: begin
              if (sending_active_q) begin
                res_d.error = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                if (prev_active_q) begin
                  has_time_d[prev_id_q] = 1'b0;
                  prev_active_d = 1'b0;
                end
                pending_d = 1'b0;
                state_d   = S_SCAN;
                kind_d    = K_GRANT;
                cnt_d     = '0;
                chk_vld_d = 1'b0;
                found_d   = 1'b0;
              end
            end
            OP_RESET: begin
              if (!f_ok || (sending_active_q && sending_id_q == fidx)) begin
                res_d.error = 1'b1;
              end else begin
                has_time_d[fidx]  = 1'b0;
                is_queued_d[fidx] = 1'b0;
                if (prev_active_q && prev_id_q == fidx) begin
                  prev_active_d = 1'b0;
                end
              end
              out_valid_d = 1'b1;
            end
            default: begin
              res_d.error = 1'b1;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      // A new flow inherits the time of the sending flow.
      S_CUR_LD: begin
        cur_time_d = vt_rd_q;
        state_d    = S_SUBMIT_FIN;
      end

      // Minimum search: one read issued and one entry compared each cycle.
      S_SCAN: begin
        vt_raddr = cnt_idx;
        if (cnt_q != CNT_END) begin
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_idx;
        end else begin
          chk_vld_d = 1'b0;
          state_d   = S_SCAN_END;
        end
        if (chk_vld_q && is_queued_q[chk_idx_q] && (!found_q || !alu_carry)) begin
          found_d   = 1'b1;
          min_d     = vt_rd_q;
          min_idx_d = chk_idx_q;
        end
      end

      S_SCAN_END: begin
        case (kind_q)
          K_CUR: begin
            cur_time_d = found_q ? min_q : '0;
            state_d    = S_SUBMIT_FIN;
          end
          K_GRANT: begin
            if (found_q) begin
              state_d = S_GRANT_LD;
            end else begin
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          K_WRAP: begin
            if (found_q) begin
              cnt_d     = '0;
              chk_vld_d = 1'b0;
              state_d   = S_SWEEP;
            end else begin
              // Nothing queued: the time restarts at the packet length.
              vt_we       = 1'b1;
              vt_wdata    = amount;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          default: begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end

      // Store the descriptor and queue the flow; with nothing sending or pending, start a grant search.
      S_SUBMIT_FIN: begin
        vt_we = need_time_q;
        lh_we = 1'b1;
        is_queued_d[flow_q] = 1'b1;
        if (!sending_active_q && !pending_q) begin
          state_d   = S_SCAN;
          kind_d    = K_GRANT;
          cnt_d     = '0;
          chk_vld_d = 1'b0;
          found_d   = 1'b0;
        end else begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Start sending the winner of the search.
      S_GRANT_LD: begin
        is_queued_d[min_idx_q] = 1'b0;
        sending_active_d   = 1'b1;
        sending_id_d       = min_idx_q;
        sending_len_d      = lh_rd_q.len;
        res_d.grant_valid  = 1'b1;
        res_d.grant_flow   = FLOW_W'(min_idx_q);
        res_d.grant_len    = lh_rd_q.len;
        res_d.grant_handle = lh_rd_q.handle;
        out_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end

      // Advance the finished flow; a carry out means the time would wrap.
      S_FIN_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = vt_rd_q;
        alu_b  = amount;
        if (!alu_carry) begin
          vt_we       = 1'b1;
          vt_wdata    = alu_res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          t_d       = vt_rd_q;
          state_d   = S_SCAN;
          kind_d    = K_WRAP;
          cnt_d     = '0;
          chk_vld_d = 1'b0;
          found_d   = 1'b0;
        end
      end

      // Subtract the lowest queued time from every queued flow.
      S_SWEEP: begin
        vt_raddr = cnt_idx;
        if (cnt_q != CNT_END) begin
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_idx;
        end else begin
          chk_vld_d = 1'b0;
          state_d   = S_WRAP_SUB;
        end
        if (chk_vld_q && is_queued_q[chk_idx_q]) begin
          vt_we    = 1'b1;
          vt_waddr = chk_idx_q;
          vt_wdata = alu_res;
        end
      end

      S_WRAP_SUB: begin
        alu_a   = t_q;
        t_d     = alu_res;
        state_d = S_WRAP_ADD;
      end

      S_WRAP_ADD: begin
        alu_op      = ALU_ADD;
        alu_a       = t_q;
        alu_b       = amount;
        vt_we       = 1'b1;
        vt_wdata    = alu_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      kind_q           <= K_CUR;
      cnt_q            <= '0;
      chk_vld_q        <= 1'b0;
      found_q          <= 1'b0;
      need_time_q      <= 1'b0;
      sending_active_q <= 1'b0;
      sending_id_q     <= '0;
      sending_len_q    <= '0;
      prev_active_q    <= 1'b0;
      prev_id_q        <= '0;
      pending_q        <= 1'b0;
      has_time_q       <= '0;
      is_queued_q      <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      kind_q           <= kind_d;
      cnt_q            <= cnt_d;
      chk_vld_q        <= chk_vld_d;
      found_q          <= found_d;
      need_time_q      <= need_time_d;
      sending_active_q <= sending_active_d;
      sending_id_q     <= sending_id_d;
      sending_len_q    <= sending_len_d;
      prev_active_q    <= prev_active_d;
      prev_id_q        <= prev_id_d;
      pending_q        <= pending_d;
      has_time_q       <= has_time_d;
      is_queued_q      <= is_queued_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    flow_q     <= flow_d;
    len_q      <= len_d;
    handle_q   <= handle_d;
    cur_time_q <= cur_time_d;
    t_q        <= t_d;
    min_q      <= min_d;
    min_idx_q  <= min_idx_d;
    chk_idx_q  <= chk_idx_d;
    res_q      <= res_d;
  end

  // Time memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (vt_we) begin
      vt_mem[vt_waddr] <= vt_wdata;
    end
    vt_rd_q <= vt_mem[vt_raddr];
  end

  // Descriptor memory, read at the current search winner.
  always_ff @(posedge clk_i) begin
    if (lh_we) begin
      lh_mem[flow_q] <= '{len: len_q, handle: handle_q};
    end
    lh_rd_q <= lh_mem[min_idx_q];
  end

  // The sending flow never also holds a queued descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_active_q |-> !is_queued_q[sending_id_q])
    else $error("sending flow is also queued");

  // A pending scheduling point means the output is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> !sending_active_q)
    else $error("scheduling point pending while sending");

  // A response is only presented once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE))
    else $error("response valid while a request is in progress");

  // A grant always starts a send of the granted flow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT_LD) |=> (sending_active_q && sending_id_q == $past(min_idx_q)))
    else $error("grant did not start a send");

  // A response never carries both a grant and a completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.grant_valid && res_q.done_valid))
    else $error("grant and completion in one response");

endmodule

`default_nettype wire
